### hdl/fpb_pkg.sv
package fpb_pkg;

    // parse phase, one-hot
    typedef enum logic [4:0] {
        PH_SKIP   = 5'b00001,
        PH_DIGITS = 5'b00010,
        PH_COMMA  = 5'b00100,
        PH_DONE   = 5'b01000,
        PH_FAIL   = 5'b10000
    } phase_t;

    typedef logic [2:0] status_t;

    localparam status_t ST_DIFFERS  = 3'd0;
    localparam status_t ST_EQUAL    = 3'd1;
    localparam status_t ST_NONDIGIT = 3'd2;
    localparam status_t ST_OVER     = 3'd3;
    localparam status_t ST_SHORT    = 3'd4;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [8:0] OCTET_MAX  = 9'd255;
    localparam logic [8:0] OCTET_SAT  = 9'd256;
    localparam logic [2:0] OCTETS     = 3'd4;

    // one input byte with its framing
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first;
        logic        last;
        logic [31:0] source_addr;
    } item_t;

    // input register contents handed to the parser
    typedef struct packed {
        logic  valid;
        item_t item;
    } stage_t;

endpackage

### hdl/fpb_if.sv
interface fpb_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first;
    logic        last;
    logic [31:0] source_addr;

    modport source (output valid, output data_byte, output first, output last,
                    output source_addr, input ready);
    modport sink   (input valid, input data_byte, input first, input last,
                    input source_addr, output ready);
endinterface

interface fpb_out_if;
    logic       valid;
    logic       ready;
    logic       bounce;
    logic [2:0] status;

    modport source (output valid, output bounce, output status, input ready);
    modport sink   (input valid, input bounce, input status, output ready);
endinterface

### hdl/fpb_in_stage.sv
module fpb_in_stage
(
    input  logic             clk,
    input  logic             rst_n,
    fpb_in_if.sink           byte_stream,
    input  logic             take,
    output fpb_pkg::stage_t  stage
);
    import fpb_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // accept a transfer whenever the register is empty or being drained
    assign byte_stream.ready = !valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (byte_stream.valid && byte_stream.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (byte_stream.valid && byte_stream.ready)
        begin
            item_reg.data_byte   <= byte_stream.data_byte;
            item_reg.first       <= byte_stream.first;
            item_reg.last        <= byte_stream.last;
            item_reg.source_addr <= byte_stream.source_addr;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

### hdl/fpb_parse.sv
module fpb_parse
(
    input  logic             clk,
    input  logic             rst_n,
    input  fpb_pkg::stage_t  stage,
    output logic             take,
    fpb_out_if.source        result
);
    import fpb_pkg::*;

    typedef struct packed {
        phase_t      phase;
        logic [8:0]  octet_value;
        logic [2:0]  octet_count;
        logic [31:0] parsed_addr;
        status_t     verdict;
    } parse_st_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic parse_st_t fail(input parse_st_t s, input status_t code);
        parse_st_t t;
        t = s;
        t.phase   = PH_FAIL;
        t.verdict = code;
        return t;
    endfunction

    // close the octet; phase stays PH_DIGITS when the parse can go on
    function automatic parse_st_t close_octet(input parse_st_t s);
        parse_st_t t;
        t = s;
        if (s.octet_value > OCTET_MAX)
        begin
            t = fail(s, ST_OVER);
        end
        else
        begin
            t.parsed_addr = {s.parsed_addr[23:0], s.octet_value[7:0]};
            t.octet_count = s.octet_count + 3'd1;
            if (t.octet_count >= OCTETS)
            begin
                t.phase = PH_DONE;
            end
        end
        return t;
    endfunction

    function automatic parse_st_t take_byte(input parse_st_t s, input logic [7:0] c);
        parse_st_t   t;
        logic [7:0]  d;
        logic [11:0] v;
        t = s;
        d = c - CH_ZERO;
        v = 12'(s.octet_value) * 12'd10 + 12'(d[3:0]);
        unique case (s.phase)
            PH_SKIP:
            begin
                if (is_ws(c))
                begin
                    t = s;
                end
                else if (is_digit(c))
                begin
                    t.octet_value = 9'(d[3:0]);
                    t.phase       = PH_DIGITS;
                end
                else
                begin
                    t = fail(s, ST_NONDIGIT);
                end
            end
            PH_DIGITS:
            begin
                if (is_digit(c))
                begin
                    t.octet_value = (v > 12'(OCTET_SAT)) ? OCTET_SAT : v[8:0];
                end
                else if (c == CH_COMMA)
                begin
                    t = close_octet(s);
                    if (t.phase == PH_DIGITS)
                    begin
                        t.phase = PH_COMMA;
                    end
                end
                else if (is_ws(c))
                begin
                    t = close_octet(s);
                    if (t.phase == PH_DIGITS)
                    begin
                        t = fail(t, ST_SHORT);
                    end
                end
                else
                begin
                    t = fail(s, ST_NONDIGIT);
                end
            end
            PH_COMMA:
            begin
                if (is_digit(c))
                begin
                    t.octet_value = 9'(d[3:0]);
                    t.phase       = PH_DIGITS;
                end
                else if (is_ws(c))
                begin
                    t = fail(s, ST_SHORT);
                end
                else
                begin
                    t = fail(s, ST_NONDIGIT);
                end
            end
            default:
            begin
                t = s;
            end
        endcase
        return t;
    endfunction

    // end-of-stream handling, which also updates the state
    function automatic parse_st_t resolve(input parse_st_t s);
        parse_st_t t;
        t = s;
        unique case (s.phase)
            PH_DIGITS:
            begin
                t = close_octet(s);
                if (t.phase == PH_DIGITS)
                begin
                    t = fail(t, ST_SHORT);
                end
            end
            PH_SKIP, PH_COMMA:
            begin
                t = fail(s, ST_SHORT);
            end
            default:
            begin
                t = s;
            end
        endcase
        return t;
    endfunction

    parse_st_t   st_reg, st_next;
    logic [31:0] src_reg, src_next;
    logic        out_valid_reg;
    logic        bounce_reg, bounce_next;
    status_t     status_reg, status_next;

    // the parse state advances only while the result register can load
    assign take = stage.valid && (!out_valid_reg || result.ready);

    // per-byte state update and verdict
    always_comb
    begin
        parse_st_t s;
        s        = st_reg;
        src_next = src_reg;
        if (stage.item.first)
        begin
            s.phase       = PH_SKIP;
            s.octet_value = '0;
            s.octet_count = '0;
            s.parsed_addr = '0;
            s.verdict     = ST_DIFFERS;
            src_next      = stage.item.source_addr;
        end
        s = take_byte(s, stage.item.data_byte);
        if (stage.item.last)
        begin
            s = resolve(s);
        end
        st_next = s;
        if (s.phase == PH_DONE)
        begin
            status_next = (s.parsed_addr != src_next) ? ST_DIFFERS : ST_EQUAL;
        end
        else if (s.phase == PH_FAIL)
        begin
            status_next = s.verdict;
        end
        else
        begin
            status_next = ST_SHORT;
        end
        bounce_next = (status_next == ST_DIFFERS);
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase       <= PH_SKIP;
            st_reg.octet_value <= '0;
            st_reg.octet_count <= '0;
            st_reg.parsed_addr <= '0;
            st_reg.verdict     <= ST_DIFFERS;
            src_reg            <= '0;
        end
        else if (take)
        begin
            st_reg  <= st_next;
            src_reg <= src_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take && stage.item.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && stage.item.last)
        begin
            bounce_reg <= bounce_next;
            status_reg <= status_next;
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.bounce = bounce_reg;
    assign result.status = status_reg;

    // a bounce is reported exactly for a differing address
    a_bounce_status: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.bounce == (result.status == ST_DIFFERS)))
        else $error("bounce flag disagrees with status");

    // no more than four octets are ever counted
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.octet_count <= OCTETS)
        else $error("octet count beyond four");

    // a completed address always has four octets
    a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.phase == PH_DONE) |-> (st_reg.octet_count == OCTETS))
        else $error("done phase without four octets");

    // a failed parse holds a failure code
    a_fail_code: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.phase == PH_FAIL) |-> (st_reg.verdict == ST_NONDIGIT ||
            st_reg.verdict == ST_OVER || st_reg.verdict == ST_SHORT))
        else $error("failed parse without a failure code");

    // the state only moves when an item is consumed
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(st_reg))
        else $error("parse state changed without a consumed byte");

endmodule

### hdl/ftp_port_bounce_check.sv
// FTP PORT bounce check. Payload bytes from the match cursor arrive on
// byte_stream, one transfer per byte; first clears the parse and samples
// source_addr, last closes it and produces one transfer on result
// (bounce, status) about the four comma-separated decimal octets found.
// A byte can be accepted every cycle while result is drained: the
// parse state is updated in the parser stage, so the sustained rate
// is one byte per cycle. After the transfer of the last byte, the
// result passes the input register, then the result register. Bytes
// without last produce no result. Without first, bytes continue the
// current parse; once a last has closed it, they leave it unchanged.
module ftp_port_bounce_check
(
    input  logic       clk,
    input  logic       rst_n,
    fpb_in_if.sink     byte_stream,
    fpb_out_if.source  result
);
    import fpb_pkg::*;

    stage_t stage;
    logic   take;

    // input register
    fpb_in_stage u_in_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .take        (take),
        .stage       (stage)
    );

    // parse state and result register
    fpb_parse u_parse
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .stage  (stage),
        .take   (take),
        .result (result)
    );

endmodule
